>>> hw/rtl/rolling_window_sum_min_max_count_top_macros.svh
// ----------------------------------------------------------------------------
// Rolling window aggregate - assertion macros
// Concurrent property wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROLLING_WINDOW_SUM_MIN_MAX_COUNT_TOP_MACROS_SVH
`define ROLLING_WINDOW_SUM_MIN_MAX_COUNT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/rwsum_pkg.sv
// ----------------------------------------------------------------------------
// Rolling window aggregate - package
// Widths, register indexes, aggregate codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwsum_pkg;

    localparam int DATA_W    = 64;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int AGG_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGG_SEL   = 2'd2;

    typedef enum logic [AGG_W-1:0] {
        AGG_SUM,
        AGG_MIN,
        AGG_MAX,
        AGG_CNT
    } t_agg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RB_RD,
        ST_RB_ACC,
        ST_LEAVE_RD,
        ST_LEAVE_WB,
        ST_ADD,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_POP_RD,
        ST_POP_CHK,
        ST_PUSH,
        ST_NEXT,
        ST_FRONT_RD,
        ST_FIN
    } t_state;

endpackage

>>> hw/rtl/rwsum_ram.sv
// ----------------------------------------------------------------------------
// Rolling window aggregate - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwsum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/rolling_window_sum_min_max_count_top.sv
// ----------------------------------------------------------------------------
// Rolling window aggregate - top level
// Sum, minimum, maximum or count of the valid samples in a sliding window.
// ----------------------------------------------------------------------------
// Input stream: tdata carries the signed 64-bit sample, tuser its valid flag,
// tlast the end of a series. Output stream: one word per input word, tdata the
// aggregate (zero when absent), tuser the present flag, tlast a copy of the
// input tlast. Registers are written over the cfg channel (always ready):
// 0 window_length, 1 min_count, 2 aggregate_select.
// Samples sit in a ring RAM; the min and max monotone deques share one RAM.
// An item's time from acceptance to its result register grows with every
// deque tail pop (amortized one pop per valid sample), as each pop waits on a
// read through the deque RAM read port. The first item after a window_length
// write first replays the stored samples of the new window from the sample
// ring, one stored position after another.
// The input takes a new word only while the sequencer idles. The result
// register lets the next item run while a word waits; the sequencer holds in
// its final state if the receiver still stalls the previous word.
// Reset empties the window and loads window_length 1, min_count 0, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rolling_window_sum_min_max_count_top_macros.svh"

module rolling_window_sum_min_max_count_top
    import rwsum_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_W-1:0]    i_s_tdata,     // [63:0] sample_value
    input  logic                 i_s_tuser,     // [0] sample_present
    input  logic                 i_s_tlast,
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_W-1:0]    o_m_tdata,     // [63:0] aggregate_value
    output logic                 o_m_tuser,     // [0] aggregate_present
    output logic                 o_m_tlast,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
    localparam int DQ_DEPTH = 2 * MAX_WINDOW;
    localparam int DQ_AW    = $clog2(DQ_DEPTH);
    localparam int DQ_W     = DATA_W + IDX_W;
    localparam int RING_W   = DATA_W + 1;

    function automatic logic [IDX_W-1:0] f_idx_sub(input logic [IDX_W-1:0] a,
                                                   input logic [WIN_W-1:0] b);
        logic [WIN_W:0] l_a;
        logic [WIN_W:0] l_b;
        l_a = (WIN_W+1)'(a);
        l_b = (WIN_W+1)'(b);
        if (l_a >= l_b) begin
            return IDX_W'(l_a - l_b);
        end
        return IDX_W'(l_a + (WIN_W+1)'(MAX_WINDOW) - l_b);
    endfunction

    function automatic logic [IDX_W-1:0] f_idx_add(input logic [IDX_W-1:0] a,
                                                   input logic [WIN_W-1:0] b);
        logic [WIN_W:0] l_s;
        l_s = (WIN_W+1)'(a) + (WIN_W+1)'(b);
        if (l_s >= (WIN_W+1)'(MAX_WINDOW)) begin
            return IDX_W'(l_s - (WIN_W+1)'(MAX_WINDOW));
        end
        return IDX_W'(l_s);
    endfunction

    function automatic logic [DQ_AW-1:0] f_dq_addr(input logic side,
                                                   input logic [IDX_W-1:0] ptr);
        if (side) begin
            return DQ_AW'(ptr) + DQ_AW'(MAX_WINDOW);
        end
        return DQ_AW'(ptr);
    endfunction

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]  r_cfg_win;
    logic [CFG_W-1:0]  r_cfg_mincnt;
    t_agg              r_cfg_agg;
    logic              r_dirty;

    logic [DATA_W-1:0] r_val;
    logic              r_vld;
    logic              r_last;

    logic [IDX_W-1:0]  r_pos;
    logic [WIN_W-1:0]  r_filled;
    logic [DATA_W-1:0] r_sum;
    logic [WIN_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_head [2];
    logic [WIN_W-1:0]  r_len  [2];
    logic              r_side;

    logic [DATA_W-1:0] r_pv;
    logic [IDX_W-1:0]  r_ppos;
    logic              r_pvld;
    logic              r_rb;
    logic [IDX_W-1:0]  r_rb_idx;
    logic [WIN_W-1:0]  r_rb_left;
    logic              r_leave;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_data;
    logic              r_o_present;
    logic              r_o_last;

    logic              w_ring_re;
    logic [IDX_W-1:0]  w_ring_raddr;
    logic              w_ring_we;
    logic [IDX_W-1:0]  w_ring_waddr;
    logic [RING_W-1:0] w_ring_wdata;
    logic [RING_W-1:0] w_ring_rdata;
    logic              w_dq_re;
    logic [DQ_AW-1:0]  w_dq_raddr;
    logic              w_dq_we;
    logic [DQ_AW-1:0]  w_dq_waddr;
    logic [DQ_W-1:0]   w_dq_wdata;
    logic [DQ_W-1:0]   w_dq_rdata;

    logic [WIN_W-1:0]  w_win;
    logic [WIN_W-1:0]  w_span;
    logic [IDX_W-1:0]  w_prev;
    logic [IDX_W-1:0]  w_head;
    logic [WIN_W-1:0]  w_len;
    logic              w_ring_rvld;
    logic [DATA_W-1:0] w_ring_rval;
    logic [DATA_W-1:0] w_dq_rval;
    logic [IDX_W-1:0]  w_dq_rpos;
    logic [IDX_W-1:0]  w_age;
    logic              w_expire;
    logic              w_pop;
    logic [WIN_W-1:0]  w_filled_next;
    logic              w_present;
    logic [DATA_W-1:0] w_result;
    logic              w_out_free;
    logic              w_accept;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    rwsum_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_ring_we),
        .i_wr_addr (w_ring_waddr),
        .i_wr_data (w_ring_wdata),
        .i_rd_en   (w_ring_re),
        .i_rd_addr (w_ring_raddr),
        .o_rd_data (w_ring_rdata)
    );

    rwsum_ram #(
        .WIDTH (DQ_W),
        .DEPTH (DQ_DEPTH)
    ) u_deque (
        .i_clk     (i_clk),
        .i_wr_en   (w_dq_we),
        .i_wr_addr (w_dq_waddr),
        .i_wr_data (w_dq_wdata),
        .i_rd_en   (w_dq_re),
        .i_rd_addr (w_dq_raddr),
        .o_rd_data (w_dq_rdata)
    );

    // ------------------------------------------------------------------
    // shared datapath terms
    // ------------------------------------------------------------------
    always_comb begin
        if (r_cfg_win == '0) begin
            w_win = WIN_W'(1);
        end else if (32'(r_cfg_win) > MAX_WINDOW) begin
            w_win = WIN_W'(MAX_WINDOW);
        end else begin
            w_win = WIN_W'(r_cfg_win);
        end
    end

    assign w_span        = (r_filled < w_win) ? r_filled : w_win;
    assign w_prev        = f_idx_sub(r_pos, WIN_W'(1));
    assign w_head        = r_head[r_side];
    assign w_len         = r_len[r_side];
    assign w_ring_rvld   = w_ring_rdata[RING_W-1];
    assign w_ring_rval   = w_ring_rdata[DATA_W-1:0];
    assign w_dq_rval     = w_dq_rdata[DQ_W-1 -: DATA_W];
    assign w_dq_rpos     = w_dq_rdata[IDX_W-1:0];
    assign w_age         = f_idx_sub(w_prev, WIN_W'(w_dq_rpos));
    assign w_expire      = ((WIN_W+1)'(w_age) + (WIN_W+1)'(1)) >= (WIN_W+1)'(w_win);
    assign w_pop         = r_side ? ($signed(w_dq_rval) <= $signed(r_pv))
                                  : ($signed(w_dq_rval) >= $signed(r_pv));
    assign w_filled_next = (32'(r_filled) >= MAX_WINDOW) ? r_filled
                                                         : r_filled + WIN_W'(1);
    assign w_out_free    = !r_o_valid || i_m_tready;
    assign w_accept      = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_cfg_mincnt == '0) begin
            w_present = (w_filled_next >= w_win) && (r_cnt != '0);
        end else begin
            w_present = 32'(r_cnt) >= 32'(r_cfg_mincnt);
        end
    end

    always_comb begin
        unique case (r_cfg_agg)
            AGG_SUM: w_result = r_sum;
            AGG_MIN: w_result = w_dq_rval;
            AGG_MAX: w_result = w_dq_rval;
            AGG_CNT: w_result = DATA_W'(r_cnt);
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = r_dirty ? ST_RB_RD : ST_LEAVE_RD;
                end
            end
            ST_RB_RD: begin
                n_state = (r_rb_left == '0) ? ST_LEAVE_RD : ST_RB_ACC;
            end
            ST_RB_ACC: begin
                n_state = w_ring_rvld ? ST_POP_RD : ST_RB_RD;
            end
            ST_LEAVE_RD: n_state = ST_LEAVE_WB;
            ST_LEAVE_WB: n_state = ST_ADD;
            ST_ADD:      n_state = ST_EXP_RD;
            ST_EXP_RD: begin
                n_state = (w_len == '0) ? ST_POP_RD : ST_EXP_CHK;
            end
            ST_EXP_CHK:  n_state = ST_POP_RD;
            ST_POP_RD: begin
                if (!r_pvld) begin
                    n_state = ST_NEXT;
                end else if (w_len == '0) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_POP_CHK;
                end
            end
            ST_POP_CHK: begin
                n_state = w_pop ? ST_POP_RD : ST_PUSH;
            end
            ST_PUSH:     n_state = ST_NEXT;
            ST_NEXT: begin
                if (!r_side) begin
                    n_state = r_rb ? ST_POP_RD : ST_EXP_RD;
                end else begin
                    n_state = r_rb ? ST_RB_RD : ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // memory controls and handshakes
    // ------------------------------------------------------------------
    always_comb begin
        w_ring_re    = 1'b0;
        w_ring_raddr = r_rb_idx;
        w_ring_we    = 1'b0;
        w_ring_waddr = r_pos;
        w_ring_wdata = {r_vld, (r_vld ? r_val : '0)};
        w_dq_re      = 1'b0;
        w_dq_raddr   = f_dq_addr(r_side, w_head);
        w_dq_we      = 1'b0;
        w_dq_waddr   = f_dq_addr(r_side, f_idx_add(w_head, w_len));
        w_dq_wdata   = {r_pv, r_ppos};
        unique case (r_state)
            ST_RB_RD: begin
                w_ring_re = (r_rb_left != '0);
            end
            ST_LEAVE_RD: begin
                w_ring_re    = (r_filled >= w_win);
                w_ring_raddr = f_idx_sub(r_pos, w_win);
            end
            ST_LEAVE_WB: begin
                w_ring_we = 1'b1;
            end
            ST_EXP_RD: begin
                w_dq_re = (w_len != '0);
            end
            ST_POP_RD: begin
                w_dq_re    = r_pvld && (w_len != '0);
                w_dq_raddr = f_dq_addr(r_side, f_idx_add(w_head, w_len - WIN_W'(1)));
            end
            ST_PUSH: begin
                w_dq_we = 1'b1;
            end
            ST_FRONT_RD: begin
                w_dq_re    = (r_cfg_agg == AGG_MIN) || (r_cfg_agg == AGG_MAX);
                w_dq_raddr = (r_cfg_agg == AGG_MAX) ? f_dq_addr(1'b1, r_head[1])
                                                    : f_dq_addr(1'b0, r_head[0]);
            end
            default: begin
            end
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;
    assign o_m_tuser   = r_o_present;
    assign o_m_tlast   = r_o_last;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win    <= CFG_W'(1);
            r_cfg_mincnt <= '0;
            r_cfg_agg    <= AGG_SUM;
            r_dirty      <= 1'b0;
        end else begin
            if (w_accept && r_dirty) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIN_LEN: begin
                        r_cfg_win <= i_cfg_data;
                        r_dirty   <= 1'b1;
                    end
                    CFG_MIN_COUNT: r_cfg_mincnt <= i_cfg_data;
                    CFG_AGG_SEL:   r_cfg_agg    <= t_agg'(i_cfg_data[AGG_W-1:0]);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_filled  <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_len[0]  <= '0;
            r_len[1]  <= '0;
            r_side    <= 1'b0;
            r_rb      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_val  <= i_s_tdata;
                        r_vld  <= i_s_tuser;
                        r_last <= i_s_tlast;
                        r_side <= 1'b0;
                        if (r_dirty) begin
                            r_rb      <= 1'b1;
                            r_rb_left <= w_span;
                            r_rb_idx  <= f_idx_sub(r_pos, w_span);
                            r_sum     <= '0;
                            r_cnt     <= '0;
                            r_head[0] <= '0;
                            r_head[1] <= '0;
                            r_len[0]  <= '0;
                            r_len[1]  <= '0;
                        end
                    end
                end
                ST_RB_RD: begin
                    if (r_rb_left == '0) begin
                        r_rb <= 1'b0;
                    end
                end
                ST_RB_ACC: begin
                    if (w_ring_rvld) begin
                        r_sum  <= r_sum + w_ring_rval;
                        r_cnt  <= r_cnt + WIN_W'(1);
                        r_pv   <= w_ring_rval;
                        r_ppos <= r_rb_idx;
                        r_pvld <= 1'b1;
                        r_side <= 1'b0;
                    end else begin
                        r_rb_idx  <= f_idx_add(r_rb_idx, WIN_W'(1));
                        r_rb_left <= r_rb_left - WIN_W'(1);
                    end
                end
                ST_LEAVE_RD: begin
                    r_leave <= (r_filled >= w_win);
                end
                ST_LEAVE_WB: begin
                    if (r_leave && w_ring_rvld) begin
                        r_sum <= r_sum - w_ring_rval;
                        r_cnt <= r_cnt - WIN_W'(1);
                    end
                end
                ST_ADD: begin
                    if (r_vld) begin
                        r_sum <= r_sum + r_val;
                        r_cnt <= r_cnt + WIN_W'(1);
                    end
                    r_pv   <= r_val;
                    r_ppos <= r_pos;
                    r_pvld <= r_vld;
                    r_side <= 1'b0;
                end
                ST_EXP_CHK: begin
                    if (w_expire) begin
                        r_head[r_side] <= f_idx_add(w_head, WIN_W'(1));
                        r_len[r_side]  <= w_len - WIN_W'(1);
                    end
                end
                ST_POP_CHK: begin
                    if (w_pop) begin
                        r_len[r_side] <= w_len - WIN_W'(1);
                    end
                end
                ST_PUSH: begin
                    r_len[r_side] <= w_len + WIN_W'(1);
                end
                ST_NEXT: begin
                    r_side <= !r_side;
                    if (r_side && r_rb) begin
                        r_rb_idx  <= f_idx_add(r_rb_idx, WIN_W'(1));
                        r_rb_left <= r_rb_left - WIN_W'(1);
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_data    <= w_present ? w_result : '0;
                        r_o_present <= w_present;
                        r_o_last    <= r_last;
                        if (r_last) begin
                            r_pos     <= '0;
                            r_filled  <= '0;
                            r_sum     <= '0;
                            r_cnt     <= '0;
                            r_head[0] <= '0;
                            r_head[1] <= '0;
                            r_len[0]  <= '0;
                            r_len[1]  <= '0;
                        end else begin
                            r_pos    <= f_idx_add(r_pos, WIN_W'(1));
                            r_filled <= w_filled_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RWS_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, w_accept, !o_s_tready)
    `RWS_ASSERT_IMPL(a_count_within_filled, i_clk, i_rst_n, r_state == ST_IDLE, r_cnt <= r_filled)
    `RWS_ASSERT_IMPL(a_deque_bounded, i_clk, i_rst_n, 1'b1, (32'(r_len[0]) <= MAX_WINDOW) && (32'(r_len[1]) <= MAX_WINDOW))
    `RWS_ASSERT_IMPL(a_absent_is_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Rolling window aggregate - testbench
// Drives a stimulus table, then random phases of samples under changing
// window, min_count and aggregate settings. Each result word is checked against
// its table entry or an in-bench window model; both streams idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rwsum_pkg::*;

    localparam int MAX_WINDOW = 1024;
    localparam int unsigned RAND_ITEMS = 1080;
    localparam int unsigned SHORT_ITEMS = 30;
    localparam int unsigned FINAL_ITEMS = 150;
    localparam int unsigned HOLD_AFTER = 400;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              present;
        logic              last;
    } word_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        word_t                word;
        logic                 typed;
        word_t                want;
    } script_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata = '0;
    logic                 i_s_tuser = 1'b0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [DATA_W-1:0]    o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    rolling_window_sum_min_max_count_top #(
        .MAX_WINDOW(MAX_WINDOW)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // window model state
    logic [DATA_W-1:0] ring_vals [MAX_WINDOW];
    logic              ring_flags [MAX_WINDOW];
    int unsigned       wr_slot = 0;
    int unsigned       seen = 0;
    logic [CFG_W-1:0]  cfg_len = 11'd1;
    logic [CFG_W-1:0]  cfg_min = 11'd0;
    t_agg              cfg_agg = AGG_SUM;

    word_t             pending_results [$];
    int unsigned       fail_count = 0;
    int unsigned       results_seen = 0;
    int unsigned       cycle_count = 0;
    logic [DATA_W-1:0] ramp_val = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_len(input logic [CFG_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_WINDOW)
            return MAX_WINDOW;
        return len;
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_WIN_LEN:   cfg_len = data;
            CFG_MIN_COUNT: cfg_min = data;
            CFG_AGG_SEL:   cfg_agg = t_agg'(data[AGG_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic window_step(input word_t s, output word_t r);
        int unsigned win, span, k, slot, cnt;
        logic [DATA_W-1:0] total;
        logic signed [DATA_W-1:0] lo, hi, v;
        logic present;
        ring_vals[wr_slot] = s.present ? s.value : '0;
        ring_flags[wr_slot] = s.present;
        wr_slot = (wr_slot + 1) % MAX_WINDOW;
        if (seen < MAX_WINDOW)
            seen++;
        win = eff_len(cfg_len);
        span = (win < seen) ? win : seen;
        cnt = 0;
        total = '0;
        lo = '0;
        hi = '0;
        for (k = 0; k < span; k++) begin
            slot = (wr_slot + MAX_WINDOW - 1 - k) % MAX_WINDOW;
            if (ring_flags[slot]) begin
                v = ring_vals[slot];
                if (cnt == 0) begin
                    lo = v;
                    hi = v;
                end else begin
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                end
                total = total + v;
                cnt++;
            end
        end
        present = (cfg_min == 0) ? (seen >= win && cnt >= 1) : (cnt >= cfg_min);
        r.value = '0;
        if (present) begin
            case (cfg_agg)
                AGG_SUM: r.value = total;
                AGG_MIN: r.value = lo;
                AGG_MAX: r.value = hi;
                default: r.value = DATA_W'(cnt);
            endcase
        end
        r.present = present;
        r.last = s.last;
        if (s.last) begin
            wr_slot = 0;
            seen = 0;
        end
    endtask

    function automatic script_row_t item_row(input logic [DATA_W-1:0] v, input logic p,
                                             input logic l);
        script_row_t row;
        row.kind = ROW_ITEM;
        row.idx = '0;
        row.data = '0;
        row.word = '{v, p, l};
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic script_row_t typed_row(input logic [DATA_W-1:0] v, input logic p,
                                              input logic l, input logic [DATA_W-1:0] wv,
                                              input logic wp);
        script_row_t row;
        row = item_row(v, p, l);
        row.typed = 1'b1;
        row.want = '{wv, wp, l};
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        script_row_t row;
        row = item_row('0, 1'b0, 1'b0);
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        logic signed [DATA_W-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 3))
                0: return MAX_POS;
                1: return MIN_NEG;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 50) begin
            s = int'($urandom_range(0, 8)) - 4;
            return s;
        end
        if (r < 65) begin
            ramp_val = ramp_val + DATA_W'($urandom_range(1, 3));
            return ramp_val;
        end
        if (r < 80) begin
            ramp_val = ramp_val - DATA_W'($urandom_range(1, 3));
            return ramp_val;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CFG_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(1, 8);
        if (r < 65) return $urandom_range(9, 64);
        if (r < 80) return $urandom_range(65, MAX_WINDOW - 1);
        if (r < 90) return MAX_WINDOW;
        if (r < 95) return 0;
        return $urandom_range(MAX_WINDOW + 1, 2047);
    endfunction

    function automatic logic [CFG_W-1:0] pick_min(input int unsigned win);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, win);
        if (r < 90) return $urandom_range(0, 2047);
        return (win < 2047) ? win + 1 : win;
    endfunction

    // hold until every expected word has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic send_word(input word_t word, input int unsigned gap, input logic typed,
                             input word_t want);
        word_t pred;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= word.value;
        i_s_tuser <= word.present;
        i_s_tlast <= word.last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        window_step(word, pred);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic report_fail(input string what, input word_t want, input word_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: want value %h present %b last %b, got value %h present %b last %b",
                     what, want.value, want.present, want.last,
                     got.value, got.present, got.last);
    endtask

    always @(posedge i_clk) begin : result_monitor
        word_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            got = '{o_m_tdata, o_m_tuser, o_m_tlast};
            if (pending_results.size() == 0) begin
                report_fail("unexpected word", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got != want)
                    report_fail("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** rolling_window_sum_min_max_count_top: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off once the output has been busy a while
    initial begin : receiver
        int unsigned r, len;
        logic held;
        held = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = $urandom_range(1, 30);
                i_m_tready <= 1'b1;
            end else if (r < 95) begin
                len = $urandom_range(1, 3);
                i_m_tready <= 1'b0;
            end else begin
                len = $urandom_range(20, 60);
                i_m_tready <= 1'b0;
            end
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        script_row_t script [$];
        script_row_t row;
        word_t word;
        int unsigned i, rand_sent, phase_end, win;
        logic long_done, no_gaps;

        // after reset: window 1, full-window mode, sum
        script.push_back(typed_row(MAX_POS, 1'b1, 1'b0, MAX_POS, 1'b1));
        script.push_back(typed_row(MIN_NEG, 1'b1, 1'b0, MIN_NEG, 1'b1));
        script.push_back(typed_row(64'hDEAD_BEEF_0BAD_F00D, 1'b0, 1'b0, '0, 1'b0));
        script.push_back(typed_row('1, 1'b1, 1'b1, '1, 1'b1));
        script.push_back(reg_row(CFG_WIN_LEN, 11'd4));
        script.push_back(reg_row(CFG_MIN_COUNT, 11'd0));
        script.push_back(reg_row(CFG_AGG_SEL, 11'(AGG_SUM)));
        script.push_back(typed_row(MAX_POS, 1'b1, 1'b0, '0, 1'b0));
        script.push_back(typed_row(MAX_POS, 1'b1, 1'b0, '0, 1'b0));
        script.push_back(typed_row(64'h1234, 1'b0, 1'b0, '0, 1'b0));
        script.push_back(item_row(64'd1, 1'b1, 1'b0));
        script.push_back(item_row(64'd2, 1'b1, 1'b0));
        script.push_back(reg_row(CFG_AGG_SEL, 11'(AGG_MIN)));
        script.push_back(item_row(MIN_NEG, 1'b1, 1'b0));
        script.push_back(item_row(MAX_POS, 1'b1, 1'b0));
        script.push_back(item_row(64'd5, 1'b0, 1'b1));
        script.push_back(reg_row(CFG_AGG_SEL, 11'(AGG_MAX)));
        script.push_back(reg_row(CFG_MIN_COUNT, 11'd2));
        script.push_back(typed_row(MIN_NEG, 1'b1, 1'b0, '0, 1'b0));
        script.push_back(item_row(-64'sd7, 1'b1, 1'b0));
        script.push_back(item_row(64'd9, 1'b0, 1'b1));
        // min_count above any window never reports a present aggregate
        script.push_back(reg_row(CFG_AGG_SEL, 11'h7FF));
        script.push_back(reg_row(CFG_MIN_COUNT, 11'h7FF));
        script.push_back(typed_row(64'd1, 1'b1, 1'b0, '0, 1'b0));
        script.push_back(typed_row(64'd2, 1'b1, 1'b1, '0, 1'b0));
        // window zero acts as one
        script.push_back(reg_row(CFG_WIN_LEN, 11'd0));
        script.push_back(reg_row(CFG_MIN_COUNT, 11'd0));
        script.push_back(typed_row(64'd3, 1'b1, 1'b0, 64'd1, 1'b1));
        script.push_back(typed_row(64'd4, 1'b0, 1'b1, '0, 1'b0));
        // oversized window saturates; unused index is dropped
        script.push_back(reg_row(CFG_WIN_LEN, 11'h7FF));
        script.push_back(reg_row(CFG_UNUSED, 11'h7FF));
        script.push_back(reg_row(CFG_MIN_COUNT, 11'd1));
        script.push_back(typed_row(MIN_NEG, 1'b1, 1'b0, 64'd1, 1'b1));
        script.push_back(item_row('0, 1'b1, 1'b0));
        script.push_back(item_row(MAX_POS, 1'b1, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < script.size(); i++) begin
            row = script[i];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_reg(row.idx, row.data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_word(row.word, pick_gap(), row.typed, row.want);
            end
        end

        rand_sent = 0;
        long_done = 1'b0;
        while (rand_sent < RAND_ITEMS) begin
            drain_results();
            if (rand_sent >= RAND_ITEMS - FINAL_ITEMS) begin
                // saturated full window over a series longer than the ring
                write_reg(CFG_WIN_LEN, $urandom_range(0, 1) ? 11'd1024 : 11'h7FF);
                write_reg(CFG_MIN_COUNT, 11'd0);
                write_reg(CFG_AGG_SEL, 11'($urandom_range(0, 2047)));
                long_done = 1'b1;
                phase_end = RAND_ITEMS;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_WIN_LEN, pick_len());
                win = eff_len(cfg_len);
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_MIN_COUNT, pick_min(win));
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_AGG_SEL, 11'($urandom_range(0, 2047)));
                phase_end = rand_sent + $urandom_range(40, 100);
                if (phase_end > RAND_ITEMS - FINAL_ITEMS)
                    phase_end = RAND_ITEMS - FINAL_ITEMS;
            end
            i_cfg_valid <= 1'b0;
            no_gaps = ($urandom_range(0, 3) == 0);
            while (rand_sent < phase_end) begin
                word.value = pick_value();
                word.present = ($urandom_range(0, 3) != 0);
                if (rand_sent < SHORT_ITEMS)
                    word.last = ($urandom_range(0, 7) == 0);
                else
                    word.last = (rand_sent == RAND_ITEMS - 1);
                send_word(word, no_gaps ? 0 : pick_gap(), 1'b0, '0);
                rand_sent++;
            end
        end

        drain_results();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** rolling_window_sum_min_max_count_top: PASSED **");
        end else begin
            $display("** rolling_window_sum_min_max_count_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rwsum_pkg.sv
hw/rtl/rwsum_ram.sv
hw/rtl/rolling_window_sum_min_max_count_top.sv
tb/testbench.sv
